// File: sv/ofp_pkg.sv
// ----------------------------------------------------------------------------
// ofp_pkg
// Shared types and constants for the odometry frame parser.
// ----------------------------------------------------------------------------
package ofp_pkg;

    localparam int BYTE_W       = 8;
    localparam int COORD_W      = 16;
    localparam int HEADING_W    = 32;
    localparam int CFG_INDEX_W  = 2;
    localparam int OUT_DATA_W   = 72;
    localparam int QUEUE_DEPTH_DEF = 2;

    // minimum payload length of a complete odometry frame
    localparam logic [BYTE_W-1:0] ODO_PAYLOAD_MIN = 8'd8;

    localparam logic [BYTE_W-1:0] HEADER_FIRST_RST  = 8'hAA;
    localparam logic [BYTE_W-1:0] HEADER_SECOND_RST = 8'hAF;
    localparam logic [BYTE_W-1:0] ODO_CODE_RST      = 8'h01;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_HEADER_FIRST  = 2'd0,
        REG_HEADER_SECOND = 2'd1,
        REG_ODO_CODE      = 2'd2
    } cfg_reg_t;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_BAD_SUM    = 2'd1,
        ST_OTHER_FUNC = 2'd2,
        ST_SHORT      = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        PH_HUNT1   = 3'd0,
        PH_HUNT2   = 3'd1,
        PH_FUNC    = 3'd2,
        PH_LEN     = 3'd3,
        PH_PAYLOAD = 3'd4,
        PH_CHECK   = 3'd5
    } phase_t;

    typedef struct packed {
        logic [BYTE_W-1:0] header_first;
        logic [BYTE_W-1:0] header_second;
        logic [BYTE_W-1:0] odometry_code;
    } ofp_cfg_t;

    // one finished frame, as handed from the parser to the store stage
    typedef struct packed {
        status_t              status;
        logic [COORD_W-1:0]   raw_x;
        logic [COORD_W-1:0]   raw_y;
        logic [HEADING_W-1:0] raw_heading;
    } ofp_frame_t;

endpackage

// File: sv/odometry_frame_parser_core.sv
// ----------------------------------------------------------------------------
// odometry_frame_parser_core
// Serial odometry frame parser with additive checksum and odometry store.
// ----------------------------------------------------------------------------
// Takes one received byte per transfer on the s_ stream, hunts the two header
// bytes, then reads a function byte, a length byte, the payload and a checksum
// byte equal to the 8-bit sum of all earlier frame bytes. Every frame produces
// exactly one result transfer on the m_ stream when its checksum byte arrives:
// a status code and the stored X, Y and heading after that frame. Only a good
// odometry frame with at least eight payload bytes updates the store, and a
// negative X or Y is dropped while the old value is held. The parser takes a
// byte every clock cycle; its only stall comes from the frame queue between
// parser and store filling up while the m_ side is held off, so with m_tready
// high the sustained rate is one byte per cycle and a result passes through
// the frame queue and the result register after its checksum byte. Register
// writes on the cfg channel are always accepted and act on the next byte.
// ----------------------------------------------------------------------------
module odometry_frame_parser_core
    import ofp_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    // input byte stream
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [BYTE_W-1:0]      s_tdata,    // [7:0] rx_byte
    // result stream
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // [1:0] status, [17:2] pos_x, [33:18] pos_y, [65:34] heading_bits,
    // [66] x_updated, [67] y_updated, [71:68] zero
    output logic [OUT_DATA_W-1:0]  m_tdata,
    // register write channel
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [BYTE_W-1:0]      cfg_data
);

    ofp_cfg_t   cfg_reg;
    logic       q_push_valid, q_push_ready;
    ofp_frame_t q_push_data;
    logic       q_pop_valid, q_pop_ready;
    ofp_frame_t q_pop_data;

    // Register file: every transfer is taken; indexes past the list are dropped.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.header_first  <= HEADER_FIRST_RST;
            cfg_reg.header_second <= HEADER_SECOND_RST;
            cfg_reg.odometry_code <= ODO_CODE_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_HEADER_FIRST:  cfg_reg.header_first  <= cfg_data;
                REG_HEADER_SECOND: cfg_reg.header_second <= cfg_data;
                REG_ODO_CODE:      cfg_reg.odometry_code <= cfg_data;
                default:           ;
            endcase
        end
    end

    // Front: parse bytes and classify each finished frame.
    ofp_front u_front
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .byte_valid  (s_tvalid),
        .byte_ready  (s_tready),
        .byte_data   (s_tdata),
        .frame_valid (q_push_valid),
        .frame_ready (q_push_ready),
        .frame       (q_push_data)
    );

    // Queue: decouple the parser from result back-pressure.
    ofp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (q_push_valid),
        .push_ready (q_push_ready),
        .push_data  (q_push_data),
        .pop_valid  (q_pop_valid),
        .pop_ready  (q_pop_ready),
        .pop_data   (q_pop_data)
    );

    // Back: update the odometry store and hold the result for transfer.
    ofp_back u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .frame_valid (q_pop_valid),
        .frame_ready (q_pop_ready),
        .frame       (q_pop_data),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

endmodule

// File: sv/ofp_front.sv
// ----------------------------------------------------------------------------
// ofp_front
// Byte parser: header hunt, checksum, payload capture and frame classification.
// ----------------------------------------------------------------------------
module ofp_front
    import ofp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  ofp_cfg_t          cfg,
    input  logic              byte_valid,
    output logic              byte_ready,
    input  logic [BYTE_W-1:0] byte_data,
    output logic              frame_valid,
    input  logic              frame_ready,
    output ofp_frame_t        frame
);

    phase_t               phase_reg, phase_next;
    logic [BYTE_W-1:0]    sum_reg, sum_next;
    logic [BYTE_W-1:0]    len_reg, len_next;
    logic [BYTE_W-1:0]    count_reg, count_next;
    logic [BYTE_W-1:0]    func_reg, func_next;
    logic [COORD_W-1:0]   raw_x_reg, raw_x_next;
    logic [COORD_W-1:0]   raw_y_reg, raw_y_next;
    logic [HEADING_W-1:0] raw_h_reg, raw_h_next;
    logic                 fire;
    logic [BYTE_W-1:0]    count_inc;

    assign byte_ready = frame_ready;
    assign fire       = byte_valid && byte_ready;
    assign count_inc  = count_reg + 8'd1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HUNT1;
            sum_reg   <= '0;
            len_reg   <= '0;
            count_reg <= '0;
            func_reg  <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            sum_reg   <= sum_next;
            len_reg   <= len_next;
            count_reg <= count_next;
            func_reg  <= func_next;
        end
    end

    always_ff @(posedge clk)
    begin
        raw_x_reg <= raw_x_next;
        raw_y_reg <= raw_y_next;
        raw_h_reg <= raw_h_next;
    end

    always_comb
    begin
        phase_next  = phase_reg;
        sum_next    = sum_reg;
        len_next    = len_reg;
        count_next  = count_reg;
        func_next   = func_reg;
        raw_x_next  = raw_x_reg;
        raw_y_next  = raw_y_reg;
        raw_h_next  = raw_h_reg;
        frame_valid = 1'b0;

        if (fire)
        begin
            unique case (phase_reg)
                PH_HUNT1:
                begin
                    if (byte_data == cfg.header_first)
                        phase_next = PH_HUNT2;
                end
                PH_HUNT2:
                begin
                    // a repeated first header byte keeps the hunt armed
                    if (byte_data == cfg.header_second)
                    begin
                        sum_next   = cfg.header_first + byte_data;
                        phase_next = PH_FUNC;
                    end
                    else if (byte_data != cfg.header_first)
                        phase_next = PH_HUNT1;
                end
                PH_FUNC:
                begin
                    func_next  = byte_data;
                    sum_next   = sum_reg + byte_data;
                    phase_next = PH_LEN;
                end
                PH_LEN:
                begin
                    len_next   = byte_data;
                    count_next = '0;
                    sum_next   = sum_reg + byte_data;
                    phase_next = (byte_data == '0) ? PH_CHECK : PH_PAYLOAD;
                end
                PH_PAYLOAD:
                begin
                    // capture the first eight bytes, big-endian
                    if (count_reg < 8'd2)
                        raw_x_next = {raw_x_reg[COORD_W-BYTE_W-1:0], byte_data};
                    else if (count_reg < 8'd4)
                        raw_y_next = {raw_y_reg[COORD_W-BYTE_W-1:0], byte_data};
                    else if (count_reg < 8'd8)
                        raw_h_next = {raw_h_reg[HEADING_W-BYTE_W-1:0], byte_data};
                    sum_next   = sum_reg + byte_data;
                    count_next = count_inc;
                    if (count_inc >= len_reg)
                        phase_next = PH_CHECK;
                end
                PH_CHECK:
                begin
                    frame_valid = 1'b1;
                    phase_next  = PH_HUNT1;
                end
                default:
                begin
                    phase_next = PH_HUNT1;
                end
            endcase
        end
    end

    always_comb
    begin
        frame.raw_x       = raw_x_reg;
        frame.raw_y       = raw_y_reg;
        frame.raw_heading = raw_h_reg;
        if (byte_data != sum_reg)
            frame.status = ST_BAD_SUM;
        else if (func_reg != cfg.odometry_code)
            frame.status = ST_OTHER_FUNC;
        else if (len_reg < ODO_PAYLOAD_MIN)
            frame.status = ST_SHORT;
        else
            frame.status = ST_OK;
    end

endmodule

// File: sv/ofp_queue.sv
// ----------------------------------------------------------------------------
// ofp_queue
// Small first-in first-out queue of finished frames.
// ----------------------------------------------------------------------------
module ofp_queue
    import ofp_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push_valid,
    output logic       push_ready,
    input  ofp_frame_t push_data,
    output logic       pop_valid,
    input  logic       pop_ready,
    output ofp_frame_t pop_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    ofp_frame_t        mem [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              push, pop;

    assign push_ready = (cnt_reg != FULL_CNT);
    assign pop_valid  = (cnt_reg != '0);
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_data   = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            cnt_next = cnt_reg + 1'b1;
        else if (pop && !push)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_data;
    end

endmodule

// File: sv/ofp_back.sv
// ----------------------------------------------------------------------------
// ofp_back
// Odometry store and result register.
// ----------------------------------------------------------------------------
module ofp_back
    import ofp_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  frame_valid,
    output logic                  frame_ready,
    input  ofp_frame_t            frame,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata
);

    logic [COORD_W-1:0]   x_reg, x_next;
    logic [COORD_W-1:0]   y_reg, y_next;
    logic [HEADING_W-1:0] h_reg, h_next;
    logic                 valid_reg;
    logic                 xu_reg, xu_next;
    logic                 yu_reg, yu_next;
    status_t              status_reg;
    logic                 take;

    assign frame_ready = !valid_reg || m_tready;
    assign take        = frame_valid && frame_ready;

    always_comb
    begin
        x_next  = x_reg;
        y_next  = y_reg;
        h_next  = h_reg;
        xu_next = 1'b0;
        yu_next = 1'b0;
        if (frame.status == ST_OK)
        begin
            // drop negative coordinates, keep the old value
            if (!frame.raw_x[COORD_W-1])
            begin
                x_next  = frame.raw_x;
                xu_next = 1'b1;
            end
            if (!frame.raw_y[COORD_W-1])
            begin
                y_next  = frame.raw_y;
                yu_next = 1'b1;
            end
            h_next = frame.raw_heading;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            x_reg     <= '0;
            y_reg     <= '0;
            h_reg     <= '0;
        end
        else
        begin
            if (take)
            begin
                valid_reg <= 1'b1;
                x_reg     <= x_next;
                y_reg     <= y_next;
                h_reg     <= h_next;
            end
            else if (m_tready)
                valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            status_reg <= frame.status;
            xu_reg     <= xu_next;
            yu_reg     <= yu_next;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {4'b0, yu_reg, xu_reg, h_reg, y_reg, x_reg, status_reg};

endmodule

// File: test/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the odometry frame parser core.
// ----------------------------------------------------------------------------
// Feeds received bytes on the s_ stream and checks every result on the m_
// stream against a byte-level model of the header hunt, checksum and
// odometry store kept in this bench. A short table of hand-built frames
// comes first, with the result typed in where it is obvious. Random frames
// follow in several register settings, mostly well formed with random
// content, mixed with noise and cut-off frames. Both sides insert random
// gaps, and one long hold-off on m_tready fills the frame queue and stalls
// the input.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ofp_pkg::*;

    localparam int CLK_HALF        = 5;
    localparam int SETTLE_CYCLES   = 8;
    localparam int PRESSURE_CYCLES = 300;
    localparam int CYCLE_LIMIT     = 400000;
    localparam int N_DIR_ROWS      = 12;

    // index outside the register map; a write to it must change nothing
    localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 2'd3;

    // one result transfer, split into its fields
    typedef struct packed {
        status_t              status;
        logic [COORD_W-1:0]   pos_x;
        logic [COORD_W-1:0]   pos_y;
        logic [HEADING_W-1:0] heading;
        logic                 x_upd;
        logic                 y_upd;
    } odo_result_t;

    // one row of the directed table: up to two loose bytes, then a frame
    typedef struct packed {
        logic [1:0]  n_lead;
        logic [15:0] lead;      // first loose byte in [15:8]
        logic [7:0]  func;
        logic [7:0]  len;
        logic [63:0] body;      // first eight payload bytes, first in [63:56]
        logic [7:0]  sum_err;   // xor applied to the correct checksum
        logic        typed;     // use want instead of the model's answer
        odo_result_t want;
    } frame_row_t;

    localparam odo_result_t NO_RESULT = '0;

    // ------------------------------------------------------------------------
    // DUT ports; every input starts at a known value
    // ------------------------------------------------------------------------
    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [BYTE_W-1:0]      s_tdata   = '0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [OUT_DATA_W-1:0]  m_tdata;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [BYTE_W-1:0]      cfg_data  = '0;

    odometry_frame_parser_core u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #CLK_HALF clk = ~clk;

    // ------------------------------------------------------------------------
    // Parser model: register copies, frame state and the odometry store
    // ------------------------------------------------------------------------
    logic [7:0]  cfg_hf   = HEADER_FIRST_RST;
    logic [7:0]  cfg_hs   = HEADER_SECOND_RST;
    logic [7:0]  cfg_code = ODO_CODE_RST;

    phase_t      p_phase  = PH_HUNT1;
    logic [7:0]  p_sum    = '0;
    logic [7:0]  p_len    = '0;
    logic [7:0]  p_cnt    = '0;
    logic [7:0]  p_func   = '0;
    logic [15:0] p_x      = '0;
    logic [15:0] p_y      = '0;
    logic [31:0] p_z      = '0;
    logic [15:0] keep_x   = '0;
    logic [15:0] keep_y   = '0;
    logic [31:0] keep_z   = '0;

    odo_result_t expected_frames[$];   // results still owed by the DUT

    // directed rows may replace the model's answer for their checksum byte
    logic        override_on  = 1'b0;
    odo_result_t override_res = '0;

    int          item_count    = 0;
    int          err_count     = 0;
    int          cycle_count   = 0;
    logic        fast_mode     = 1'b0;  // no gaps on either side
    int          pressure_req  = 0;     // bumped by the stimulus to ask for a hold-off
    int          pressure_seen = 0;
    int          stall_left    = 0;

    frame_row_t  dir_rows[N_DIR_ROWS];

    // Advance the model by one accepted byte; flag a result at the checksum byte.
    task automatic advance_parser(input logic [7:0] b, output bit produced,
                                  output odo_result_t res);
        produced = 1'b0;
        res      = '0;
        case (p_phase)
            PH_HUNT2: begin
                if (b == cfg_hs) begin
                    p_sum   = cfg_hf + b;
                    p_phase = PH_FUNC;
                end else if (b != cfg_hf) begin
                    // a repeated first header byte keeps the hunt at stage two
                    p_phase = PH_HUNT1;
                end
            end
            PH_FUNC: begin
                p_func  = b;
                p_sum   = p_sum + b;
                p_phase = PH_LEN;
            end
            PH_LEN: begin
                p_len = b;
                p_cnt = '0;
                p_sum = p_sum + b;
                // zero length: the next byte is already the checksum
                if (b == 8'd0)
                    p_phase = PH_CHECK;
                else
                    p_phase = PH_PAYLOAD;
            end
            PH_PAYLOAD: begin
                // capture only the first eight bytes, sum them all
                if (p_cnt < 8'd2)
                    p_x = {p_x[7:0], b};
                else if (p_cnt < 8'd4)
                    p_y = {p_y[7:0], b};
                else if (p_cnt < 8'd8)
                    p_z = {p_z[23:0], b};
                p_sum = p_sum + b;
                p_cnt = p_cnt + 8'd1;
                if (p_cnt >= p_len)
                    p_phase = PH_CHECK;
            end
            PH_CHECK: begin
                produced = 1'b1;
                if (b != p_sum) begin
                    res.status = ST_BAD_SUM;
                end else if (p_func != cfg_code) begin
                    res.status = ST_OTHER_FUNC;
                end else if (p_len < ODO_PAYLOAD_MIN) begin
                    res.status = ST_SHORT;
                end else begin
                    res.status = ST_OK;
                    // drop negative coordinates, hold the old value
                    if (!p_x[15]) begin
                        keep_x    = p_x;
                        res.x_upd = 1'b1;
                    end
                    if (!p_y[15]) begin
                        keep_y    = p_y;
                        res.y_upd = 1'b1;
                    end
                    keep_z = p_z;
                end
                res.pos_x   = keep_x;
                res.pos_y   = keep_y;
                res.heading = keep_z;
                p_phase     = PH_HUNT1;
            end
            default: begin
                if (b == cfg_hf)
                    p_phase = PH_HUNT2;
                else
                    p_phase = PH_HUNT1;
            end
        endcase
    endtask

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    function automatic int next_gap();
        int r;
        if (fast_mode)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 10);
        return $urandom_range(20, 50);
    endfunction

    function automatic logic [7:0] pick_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return ODO_PAYLOAD_MIN;
        if (r < 80)
            return 8'($urandom_range(0, 7));
        if (r < 94)
            return 8'($urandom_range(9, 20));
        if (r < 98)
            return 8'($urandom_range(21, 60));
        return 8'hFF;
    endfunction

    function automatic logic [7:0] pick_func();
        if ($urandom_range(0, 99) < 80)
            return cfg_code;
        return 8'($urandom);
    endfunction

    function automatic logic [7:0] pick_sum_err();
        if ($urandom_range(0, 99) < 85)
            return 8'h00;
        return 8'($urandom_range(1, 255));
    endfunction

    // Offer one byte, hold it until the transfer, then predict and maybe idle.
    // Called right after a rising edge.
    task automatic send_byte(input logic [7:0] b);
        bit          produced;
        odo_result_t res;
        int          gap;
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do
            @(posedge clk);
        while (!s_tready);
        item_count++;
        advance_parser(b, produced, res);
        if (produced)
            expected_frames.push_back(override_on ? override_res : res);
        gap = next_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Send a whole frame under the current header bytes. Payload beyond the
    // first eight bytes is random; the checksum is xored with sum_err.
    task automatic send_frame(input logic [7:0] func, input logic [7:0] len,
                              input logic [63:0] body, input logic [7:0] sum_err,
                              input logic typed, input odo_result_t want);
        logic [7:0] sum;
        logic [7:0] pb;
        sum = cfg_hf + cfg_hs + func + len;
        send_byte(cfg_hf);
        send_byte(cfg_hs);
        send_byte(func);
        send_byte(len);
        for (int i = 0; i < int'(len); i++) begin
            if (i < 8)
                pb = body[63 - 8*i -: 8];
            else
                pb = 8'($urandom);
            sum = sum + pb;
            send_byte(pb);
        end
        override_on  = typed;
        override_res = want;
        send_byte(sum ^ sum_err);
        override_on  = 1'b0;
    endtask

    // Drop valid and let every owed result come out, then let the pipe settle.
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (expected_frames.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Hold one register write until its transfer, then update the copy.
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [7:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            REG_HEADER_FIRST:  cfg_hf   = val;
            REG_HEADER_SECOND: cfg_hs   = val;
            REG_ODO_CODE:      cfg_code = val;
            default: ;
        endcase
    endtask

    task automatic set_config(input logic [7:0] hf, input logic [7:0] hs,
                              input logic [7:0] code);
        wait_idle();
        write_reg(REG_HEADER_FIRST, hf);
        write_reg(REG_HEADER_SECOND, hs);
        write_reg(REG_ODO_CODE, code);
        cfg_valid <= 1'b0;
    endtask

    // Random traffic: mostly whole frames, some noise and cut-off frames.
    task automatic run_random(input int n_items);
        int start;
        int r;
        start = item_count;
        while (item_count - start < n_items) begin
            r = $urandom_range(0, 99);
            if (r < 12) begin
                repeat ($urandom_range(1, 6)) send_byte(8'($urandom));
            end else if (r < 20) begin
                // abandon a frame early; the next bytes land in its payload
                send_byte(cfg_hf);
                send_byte(cfg_hs);
                send_byte(pick_func());
                send_byte(8'($urandom_range(1, 20)));
                repeat ($urandom_range(0, 3)) send_byte(8'($urandom));
            end else begin
                send_frame(pick_func(), pick_length(), {$urandom, $urandom},
                           pick_sum_err(), 1'b0, NO_RESULT);
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Result side: check each transfer, then choose the next m_tready
    // ------------------------------------------------------------------------
    always @(posedge clk) begin
        odo_result_t seen;
        odo_result_t want;
        if (rst_n) begin
            if (m_tvalid && m_tready) begin
                seen.status  = status_t'(m_tdata[1:0]);
                seen.pos_x   = m_tdata[17:2];
                seen.pos_y   = m_tdata[33:18];
                seen.heading = m_tdata[65:34];
                seen.x_upd   = m_tdata[66];
                seen.y_upd   = m_tdata[67];
                if (expected_frames.size() == 0) begin
                    $error("result transfer with nothing expected, status %0d",
                           seen.status);
                    err_count++;
                end else begin
                    want = expected_frames.pop_front();
                    if (seen.status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, seen.status);
                        err_count++;
                    end
                    if (seen.pos_x !== want.pos_x) begin
                        $error("pos_x: expected %0d, got %0d",
                               $signed(want.pos_x), $signed(seen.pos_x));
                        err_count++;
                    end
                    if (seen.pos_y !== want.pos_y) begin
                        $error("pos_y: expected %0d, got %0d",
                               $signed(want.pos_y), $signed(seen.pos_y));
                        err_count++;
                    end
                    if (seen.heading !== want.heading) begin
                        $error("heading_bits: expected %h, got %h",
                               want.heading, seen.heading);
                        err_count++;
                    end
                    if (seen.x_upd !== want.x_upd) begin
                        $error("x_updated: expected %0d, got %0d", want.x_upd, seen.x_upd);
                        err_count++;
                    end
                    if (seen.y_upd !== want.y_upd) begin
                        $error("y_updated: expected %0d, got %0d", want.y_upd, seen.y_upd);
                        err_count++;
                    end
                end
            end

            // hold off for a counted stretch when asked, else idle at random
            if (stall_left > 0) begin
                m_tready <= 1'b0;
                stall_left--;
            end else if (pressure_req != pressure_seen) begin
                pressure_seen = pressure_req;
                stall_left    = PRESSURE_CYCLES - 1;
                m_tready     <= 1'b0;
            end else if (fast_mode) begin
                m_tready <= 1'b1;
            end else if ($urandom_range(0, 99) < 70) begin
                m_tready <= 1'b1;
            end else begin
                m_tready <= 1'b0;
                if ($urandom_range(0, 99) < 95)
                    stall_left = $urandom_range(0, 3);
                else
                    stall_left = $urandom_range(20, 60);
            end
        end
    end

    // Watchdog: end a hung run.
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        frame_row_t row;

        // Directed frames at reset settings. Typed results follow the store
        // from zero: X, Y and Z replaced, negative X held, negative Y held,
        // then bad checksum, other function and short payloads leave it alone.
        dir_rows[0]  = '{2'd2, 16'h00FF, ODO_CODE_RST, 8'd8, 64'h7FFF_0000_FFFF_FFFF, 8'h00,
                         1'b1, '{ST_OK, 16'h7FFF, 16'h0000, 32'hFFFF_FFFF, 1'b1, 1'b1}};
        // loose first header byte: the hunt restarts on the repeated one
        dir_rows[1]  = '{2'd1, 16'hAA00, ODO_CODE_RST, 8'd8, 64'h8000_1234_3F80_0000, 8'h00,
                         1'b1, '{ST_OK, 16'h7FFF, 16'h1234, 32'h3F80_0000, 1'b0, 1'b1}};
        dir_rows[2]  = '{2'd0, 16'h0000, ODO_CODE_RST, 8'd8, 64'h0001_FFFF_0000_0000, 8'h00,
                         1'b1, '{ST_OK, 16'h0001, 16'h1234, 32'h0000_0000, 1'b1, 1'b0}};
        dir_rows[3]  = '{2'd0, 16'h0000, ODO_CODE_RST, 8'd8, 64'h1111_2222_3333_4444, 8'h01,
                         1'b1, '{ST_BAD_SUM, 16'h0001, 16'h1234, 32'h0, 1'b0, 1'b0}};
        // other function with zero length
        dir_rows[4]  = '{2'd0, 16'h0000, 8'hFF, 8'd0, 64'h0, 8'h00,
                         1'b1, '{ST_OTHER_FUNC, 16'h0001, 16'h1234, 32'h0, 1'b0, 1'b0}};
        dir_rows[5]  = '{2'd0, 16'h0000, ODO_CODE_RST, 8'd7, 64'h0, 8'h00,
                         1'b1, '{ST_SHORT, 16'h0001, 16'h1234, 32'h0, 1'b0, 1'b0}};
        dir_rows[6]  = '{2'd0, 16'h0000, ODO_CODE_RST, 8'd0, 64'h0, 8'h00,
                         1'b1, '{ST_SHORT, 16'h0001, 16'h1234, 32'h0, 1'b0, 1'b0}};
        // broken header, then a frame of another function
        dir_rows[7]  = '{2'd2, 16'hAA00, 8'h00, 8'd3, 64'hFF00_FF00_0000_0000, 8'h00,
                         1'b0, NO_RESULT};
        // stray second header byte while hunting, then a long payload
        dir_rows[8]  = '{2'd1, 16'hAF00, ODO_CODE_RST, 8'd12, 64'h0102_0304_0506_0708, 8'h00,
                         1'b0, NO_RESULT};
        dir_rows[9]  = '{2'd0, 16'h0000, ODO_CODE_RST, 8'd8, 64'h0, 8'h00,
                         1'b0, NO_RESULT};
        dir_rows[10] = '{2'd0, 16'h0000, ODO_CODE_RST, 8'd8, 64'hFFFF_FFFF_FFFF_FFFF, 8'hFF,
                         1'b1, '{ST_BAD_SUM, 16'h0, 16'h0, 32'h0, 1'b0, 1'b0}};
        dir_rows[11] = '{2'd0, 16'h0000, ODO_CODE_RST, 8'd8, 64'hFFFF_FFFF_FFFF_FFFF, 8'h00,
                         1'b1, '{ST_OK, 16'h0, 16'h0, 32'hFFFF_FFFF, 1'b0, 1'b0}};

        // reset once, then release
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // walk the directed table
        for (int i = 0; i < N_DIR_ROWS; i++) begin
            row = dir_rows[i];
            if (row.n_lead > 2'd0)
                send_byte(row.lead[15:8]);
            if (row.n_lead > 2'd1)
                send_byte(row.lead[7:0]);
            send_frame(row.func, row.len, row.body, row.sum_err, row.typed, row.want);
        end
        run_random(40);

        // all-zero and all-one register extremes
        set_config(8'h00, 8'hFF, 8'hFF);
        run_random(50);

        // long hold-off on the result side while bytes keep coming
        set_config(8'hFF, 8'h00, 8'h00);
        pressure_req++;
        run_random(60);

        // both header bytes equal, back to back on both sides
        set_config(8'h5A, 8'h5A, 8'($urandom));
        fast_mode = 1'b1;
        run_random(50);
        wait_idle();
        fast_mode = 1'b0;

        // random registers, plus a write to an unused index
        set_config(8'($urandom), 8'($urandom), 8'($urandom));
        write_reg(REG_UNUSED, 8'($urandom));
        cfg_valid <= 1'b0;
        run_random(50);

        // back to reset values
        set_config(HEADER_FIRST_RST, HEADER_SECOND_RST, ODO_CODE_RST);
        run_random(40);

        wait_idle();
        if (err_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// File: files.f
sv/ofp_pkg.sv
sv/ofp_front.sv
sv/ofp_queue.sv
sv/ofp_back.sv
sv/odometry_frame_parser_core.sv
test/tb.sv
